// ===== rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared constants and command codes for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TASKS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Results reported per tick at most
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Overflow counter and its reset period
    localparam int         TICK_W       = 8;
    localparam logic [7:0] TICK_DEFAULT = 8'd32;

    // Input field widths
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int FIELD_W = 16;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // APB port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Command codes carried in s_tuser
    localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OVERFLOW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_RUN  = 2'd2;

    // Register word index decoded from paddr[2]
    localparam logic REG_OVERFLOWS_PER_TICK = 1'b0;

endpackage

// ===== rtl/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Priority-indexed table of periodic tasks, stepped by divided timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser carries the command (create, timer overflow,
//   set running flag), s_tdata the slot, period, initial delay and running
//   flag. Create and set-running commands, and overflows that do not end a
//   tick, leave s_tready high for the next command.
//   An overflow that completes a tick starts a scan of the slot table: one
//   shared decrement/compare unit visits one slot per cycle unless a stall
//   holds it, and a tick runs through accept, MAX_TASKS scan steps and a final
//   flush. s_tready stays low for the whole scan.
//   Result stream (m_*): one transfer per due slot, at most MAX_RESULTS per tick, in slot
//   order, with m_tlast on the final one; a tick with no due slot sends none.
//   Results pass a hold stage and then an output register, so a stall holds
//   the scan only when both are full, m_tready is low and another slot falls
//   due; a finished result may wait while new commands are accepted.
//   APB: register 0 (overflows_per_tick) at byte address 0, reset value 32.
//   Reset clears the valid and running flags, the overflow count and the
//   output register; periods and countdowns are written by each create.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
    parameter int MAX_TASKS   = ptts_pkg::MAX_TASKS_DEF,
    parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Command input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] slot, [18:3] period, [34:19] initial_delay, [35] running, rest zero
    input  logic [ptts_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [ptts_pkg::CMD_W-1:0]      s_tuser,
    // Due task output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] due_slot, rest zero
    output logic [ptts_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptts_pkg::PADDR_W-1:0]    paddr,
    input  logic [ptts_pkg::PDATA_W-1:0]    pwdata,
    output logic [ptts_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import ptts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Control state
    logic [1:0]             state_reg;
    logic [TICK_W-1:0]      ovf_per_tick_reg;
    logic [TICK_W-1:0]      ovf_count_reg;
    logic [MAX_TASKS-1:0]   valid_reg;
    logic [MAX_TASKS-1:0]   running_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [RES_CNT_W-1:0]   res_cnt_reg;
    logic                   hold_valid_reg;
    logic [SLOT_W-1:0]      hold_slot_reg;
    logic                   m_tvalid_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic                   m_tlast_reg;

    // Task table payload
    logic [COUNT_WIDTH-1:0] period_reg    [MAX_TASKS];
    logic [COUNT_WIDTH-1:0] countdown_reg [MAX_TASKS];

    // Input field unpacking
    logic [SLOT_W-1:0]      in_slot;
    logic [FIELD_W-1:0]     in_period;
    logic [FIELD_W-1:0]     in_delay;
    logic                   in_running;
    logic                   in_accept;
    logic                   slot_ok;
    logic [IDX_W-1:0]       wr_idx;
    logic [TICK_W-1:0]      ovf_count_next;

    // Scan datapath
    logic                   cur_active;
    logic                   cur_due;
    logic [COUNT_WIDTH-1:0] dec_operand;
    logic [COUNT_WIDTH-1:0] dec_result;
    logic                   emit;
    logic                   out_free;
    logic                   stall;
    logic                   step;
    logic                   push_mid;
    logic                   push_last;
    logic                   cfg_write;

    assign in_slot    = s_tdata[SLOT_W-1:0];
    assign in_period  = s_tdata[SLOT_W +: FIELD_W];
    assign in_delay   = s_tdata[SLOT_W + FIELD_W +: FIELD_W];
    assign in_running = s_tdata[SLOT_W + 2*FIELD_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_ok   = (32'(in_slot) < MAX_TASKS);
    assign wr_idx    = IDX_W'(in_slot);
    assign ovf_count_next = ovf_count_reg + TICK_W'(1);

    // Shared decrement unit: reload from period when due, else count down
    assign cur_active  = valid_reg[scan_idx_reg] && running_reg[scan_idx_reg];
    assign cur_due     = cur_active && (countdown_reg[scan_idx_reg] == '0);
    assign dec_operand = cur_due ? period_reg[scan_idx_reg] : countdown_reg[scan_idx_reg];
    assign dec_result  = (dec_operand == '0) ? '0 : dec_operand - COUNT_WIDTH'(1);

    // Hold one result back so the final one can carry tlast
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = cur_due && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign stall     = emit && hold_valid_reg && !out_free;
    assign step      = (state_reg == ST_SCAN) && !stall;
    assign push_mid  = step && emit && hold_valid_reg;
    assign push_last = (state_reg == ST_FLUSH) && hold_valid_reg && out_free;

    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_OVERFLOWS_PER_TICK);

    // Sequencer and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ovf_per_tick_reg <= TICK_DEFAULT;
            ovf_count_reg    <= '0;
            valid_reg        <= '0;
            running_reg      <= '0;
            scan_idx_reg     <= '0;
            res_cnt_reg      <= '0;
            hold_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                ovf_per_tick_reg <= pwdata[TICK_W-1:0];
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        case (s_tuser)
                            CMD_CREATE: begin
                                if (slot_ok) begin
                                    valid_reg[wr_idx]   <= 1'b1;
                                    running_reg[wr_idx] <= in_running;
                                end
                            end
                            CMD_SET_RUN: begin
                                if (slot_ok) begin
                                    running_reg[wr_idx] <= in_running;
                                end
                            end
                            CMD_OVERFLOW: begin
                                if (ovf_count_next == ovf_per_tick_reg) begin
                                    ovf_count_reg <= '0;
                                    scan_idx_reg  <= '0;
                                    res_cnt_reg   <= '0;
                                    state_reg     <= ST_SCAN;
                                end else begin
                                    ovf_count_reg <= ovf_count_next;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (step) begin
                        if (emit) begin
                            hold_valid_reg <= 1'b1;
                            res_cnt_reg    <= res_cnt_reg + RES_CNT_W'(1);
                        end
                        if (scan_idx_reg == LAST_IDX) begin
                            state_reg <= ST_FLUSH;
                        end else begin
                            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!hold_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Table payload: create writes, scan steps update the visited active slot
    always_ff @(posedge aclk) begin
        if (in_accept && (s_tuser == CMD_CREATE) && slot_ok) begin
            period_reg[wr_idx]    <= COUNT_WIDTH'(in_period);
            countdown_reg[wr_idx] <= COUNT_WIDTH'(in_delay);
        end else if (step && cur_active) begin
            countdown_reg[scan_idx_reg] <= dec_result;
        end
        if (step && emit) begin
            hold_slot_reg <= SLOT_W'(scan_idx_reg);
        end
    end

    // Output register: load on a transfer out of the hold stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push_mid || push_last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_mid || push_last) begin
            m_slot_reg  <= hold_slot_reg;
            m_tlast_reg <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_slot_reg);
    assign m_tlast  = m_tlast_reg;

    // APB read-back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OVERFLOWS_PER_TICK) ? PDATA_W'(ovf_per_tick_reg) : '0;

endmodule

// ===== rtl/ptts_checker.sv =====
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level assertions for the periodic task tick scheduler, bound to top.
// ----------------------------------------------------------------------------
module ptts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ptts_pkg::CMD_W-1:0]      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ptts_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);
    import ptts_pkg::*;

    // Output register is empty after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Table writes leave the input ready for the next command
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != CMD_OVERFLOW) |=> s_tready)
        else $error("non-overflow command held the input");

    // Table writes never start a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != CMD_OVERFLOW) |=> !$rose(m_tvalid))
        else $error("result appeared after a table write");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
